// ----- src/cst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// shared types and codes for the counting semaphore table
// ----------------------------------------------------------------------------
package cst_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_FREE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_LIMIT    = 3'd4
  } status_e;

  localparam int unsigned IdxW   = 5;
  localparam int unsigned CountW = 16;
  localparam int unsigned EnvW   = 10;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  owner_id;
    logic [63:0] name_tag;
    logic [14:0] initial_value;
    logic [9:0]  env_id;
    logic [4:0]  sem_index;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] sem_id;
    logic       blocked;
    logic       wake_valid;
    logic [9:0] woken_env;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request and run lookup
    logic execute;   // apply the operation, build the response
    logic finish;    // store dequeued waiter into response
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read; // operation reads the wait store
  } sts_t;

endpackage

// ----- src/cst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl
// sequencer: load, lookup, execute, optional queue read, respond
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cst_pkg::cmd_t cmd_o,
  input  cst_pkg::sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_EXEC, S_READ, S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i && !in_stall_o;
    cmd_o.execute = (state_q == S_EXEC);
    cmd_o.finish  = (state_q == S_READ);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_o.load) state_q <= S_LOOK;
        S_LOOK: state_q <= S_EXEC;
        S_EXEC: begin
          if (sts_i.need_read) begin
            state_q <= S_READ;
          end else begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        S_READ: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/cst_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_dp
// slot table, lookup, count update and per-slot wait queue memory
// ----------------------------------------------------------------------------
module cst_dp #(
  parameter int unsigned SemSlots   = 16,
  parameter int unsigned QueueDepth = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cst_pkg::req_t req_i,
  output cst_pkg::rsp_t rsp_o,
  input  cst_pkg::cmd_t cmd_i,
  output cst_pkg::sts_t sts_o
);

  localparam int unsigned SlotW = (SemSlots > 1) ? $clog2(SemSlots) : 1;
  localparam int unsigned PosW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW = $clog2(SemSlots * QueueDepth);
  localparam int unsigned StoreN = SemSlots * QueueDepth;
  localparam logic signed [cst_pkg::CountW-1:0] CntMin = {1'b1, {(cst_pkg::CountW-1){1'b0}}};
  localparam logic signed [cst_pkg::CountW-1:0] CntMax = {1'b0, {(cst_pkg::CountW-1){1'b1}}};

  logic                              used_q  [SemSlots];
  logic [9:0]                        owner_q [SemSlots];
  logic [63:0]                       name_q  [SemSlots];
  logic signed [cst_pkg::CountW-1:0] count_q [SemSlots];
  logic [PosW-1:0]                   head_q  [SemSlots];
  logic [FillW-1:0]                  fill_q  [SemSlots];
  logic [cst_pkg::EnvW-1:0]          store_q [StoreN];

  cst_pkg::req_t req_q;
  cst_pkg::rsp_t rsp_q;
  cst_pkg::rsp_t rsp_d;

  // lookup results, registered after the load cycle
  logic             hit_q, free_q;
  logic [SlotW-1:0] hit_idx_q, free_idx_q;
  logic             hit_c, free_c;
  logic [SlotW-1:0] hit_idx_c, free_idx_c;
  logic [AddrW-1:0] rd_addr;
  logic [cst_pkg::EnvW-1:0] rd_data_q;

  // priority search, lowest index wins
  always_comb begin
    hit_c = 1'b0; free_c = 1'b0; hit_idx_c = '0; free_idx_c = '0;
    for (int i = SemSlots - 1; i >= 0; i--) begin
      if (used_q[i] && owner_q[i] == req_q.owner_id && name_q[i] == req_q.name_tag) begin
        hit_c = 1'b1; hit_idx_c = SlotW'(i);
      end
      if (!used_q[i]) begin
        free_c = 1'b1; free_idx_c = SlotW'(i);
      end
    end
  end

  logic signed [cst_pkg::CountW-1:0] cnt;
  logic [FillW-1:0] fil;
  logic [PosW-1:0]  hd;
  logic [PosW:0]    tail_sum;
  logic [PosW-1:0]  tail;
  logic             sig_wake;

  always_comb begin
    cnt      = count_q[hit_idx_q];
    fil      = fill_q[hit_idx_q];
    hd       = head_q[hit_idx_q];
    tail_sum = {1'b0, hd} + (PosW+1)'(fil);
    tail     = (tail_sum >= (PosW+1)'(QueueDepth)) ?
               PosW'(tail_sum - (PosW+1)'(QueueDepth)) : PosW'(tail_sum);
    // the incremented count stays at or below zero
    sig_wake = (req_q.op == cst_pkg::OP_SIGNAL) && hit_q && (cnt < CntMax) &&
               (cnt < 0) && (fil != '0);
  end

  assign sts_o.need_read = sig_wake;
  assign rsp_o = rsp_q;
  assign rd_addr = AddrW'(32'(hit_idx_q) * QueueDepth + 32'(hd));

  logic [PosW:0] hd_inc;
  assign hd_inc = {1'b0, hd} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SemSlots; i++) begin
        used_q[i]  <= 1'b0;
        owner_q[i] <= '0;
        name_q[i]  <= '0;
        count_q[i] <= '0;
        head_q[i]  <= '0;
        fill_q[i]  <= '0;
      end
    end else if (cmd_i.execute) begin
      unique case (cst_pkg::op_e'(req_q.op))
        cst_pkg::OP_CREATE: begin
          if (!hit_q && free_q) begin
            used_q[free_idx_q]  <= 1'b1;
            owner_q[free_idx_q] <= req_q.owner_id;
            name_q[free_idx_q]  <= req_q.name_tag;
            count_q[free_idx_q] <= cst_pkg::CountW'(req_q.initial_value);
            head_q[free_idx_q]  <= '0;
            fill_q[free_idx_q]  <= '0;
          end
        end
        cst_pkg::OP_WAIT: begin
          if (hit_q && cnt != CntMin) begin
            if (cnt <= 0) begin
              if (fil < FillW'(QueueDepth)) begin
                fill_q[hit_idx_q]  <= fil + 1'b1;
                count_q[hit_idx_q] <= cnt - 1'b1;
              end
            end else begin
              count_q[hit_idx_q] <= cnt - 1'b1;
            end
          end
        end
        cst_pkg::OP_SIGNAL: begin
          if (hit_q && cnt != CntMax) begin
            count_q[hit_idx_q] <= cnt + 1'b1;
            if (sig_wake) begin
              head_q[hit_idx_q] <= (hd_inc >= (PosW+1)'(QueueDepth)) ? '0 : PosW'(hd_inc);
              fill_q[hit_idx_q] <= fil - 1'b1;
            end
          end
        end
        cst_pkg::OP_FREE: begin
          if (32'(req_q.sem_index) < SemSlots) begin
            used_q[SlotW'(req_q.sem_index)]  <= 1'b0;
            owner_q[SlotW'(req_q.sem_index)] <= '0;
            name_q[SlotW'(req_q.sem_index)]  <= '0;
            count_q[SlotW'(req_q.sem_index)] <= '0;
            head_q[SlotW'(req_q.sem_index)]  <= '0;
            fill_q[SlotW'(req_q.sem_index)]  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // response build
  always_comb begin
    rsp_d = '0;
    unique case (cst_pkg::op_e'(req_q.op))
      cst_pkg::OP_CREATE: begin
        if (hit_q) begin
          rsp_d.status = cst_pkg::ST_EXISTS;
          rsp_d.sem_id = 4'(hit_idx_q);
        end else if (!free_q) begin
          rsp_d.status = cst_pkg::ST_FULL;
        end else begin
          rsp_d.status = cst_pkg::ST_OK;
          rsp_d.sem_id = 4'(free_idx_q);
        end
      end
      cst_pkg::OP_WAIT: begin
        if (!hit_q) begin
          rsp_d.status = cst_pkg::ST_NOTFOUND;
        end else begin
          rsp_d.sem_id = 4'(hit_idx_q);
          if (cnt == CntMin) begin
            rsp_d.status = cst_pkg::ST_LIMIT;
          end else if (cnt <= 0) begin
            if (fil >= FillW'(QueueDepth)) begin
              rsp_d.status = cst_pkg::ST_LIMIT;
            end else begin
              rsp_d.status  = cst_pkg::ST_OK;
              rsp_d.blocked = 1'b1;
            end
          end else begin
            rsp_d.status = cst_pkg::ST_OK;
          end
        end
      end
      cst_pkg::OP_SIGNAL: begin
        if (!hit_q) begin
          rsp_d.status = cst_pkg::ST_NOTFOUND;
        end else begin
          rsp_d.sem_id     = 4'(hit_idx_q);
          rsp_d.status     = (cnt == CntMax) ? cst_pkg::ST_LIMIT : cst_pkg::ST_OK;
          rsp_d.wake_valid = sig_wake;
        end
      end
      cst_pkg::OP_FREE: begin
        rsp_d.sem_id = req_q.sem_index[3:0];
        rsp_d.status = (32'(req_q.sem_index) < SemSlots) ?
                       cst_pkg::ST_OK : cst_pkg::ST_NOTFOUND;
      end
      default: ;
    endcase
  end

  // request capture, lookup register, response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    hit_q      <= hit_c;
    hit_idx_q  <= hit_idx_c;
    free_q     <= free_c;
    free_idx_q <= free_idx_c;
    if (cmd_i.execute) begin
      rsp_q <= rsp_d;
    end else if (cmd_i.finish) begin
      rsp_q.woken_env <= rd_data_q;
    end
  end

  // wait queue memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && req_q.op == cst_pkg::OP_WAIT && hit_q && cnt != CntMin &&
        cnt <= 0 && fil < FillW'(QueueDepth)) begin
      store_q[AddrW'(32'(hit_idx_q) * QueueDepth + 32'(tail))] <= req_q.env_id;
    end
    if (cmd_i.execute && sig_wake) rd_data_q <= store_q[rd_addr];
  end

endmodule

// ----- src/counting_semaphore_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table
// semaphore slot table with per-slot fifo wait queues
// ----------------------------------------------------------------------------
// One request at a time. The request is captured, the parallel owner/name
// lookup is registered, then execute registers the result; a signal that
// wakes a waiter adds a read state, since the waiter id comes from the wait
// queue memory through its registered read port. The next request is taken
// once the result has been transferred or in the cycle it is. Slots clear
// on reset; the wait queue memory is not cleared, only entries written by a
// wait are ever read.
module counting_semaphore_table #(
  parameter int unsigned SEM_SLOTS   = 16,
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cst_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cst_pkg::rsp_t out_data_o
);

  cst_pkg::cmd_t cmd;  // sequencer commands
  cst_pkg::sts_t sts;  // datapath status

  cst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  cst_dp #(.SemSlots(SEM_SLOTS), .QueueDepth(QUEUE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .rsp_o(out_data_o), .cmd_i(cmd), .sts_o(sts)
  );

endmodule

// ----- src/cst_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker
// port level checks for the semaphore table
// ----------------------------------------------------------------------------
module cst_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input cst_pkg::rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transfer taken while busy");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too soon");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.blocked && out_data_o.wake_valid))
    else $error("blocked and woken together");

endmodule

bind counting_semaphore_table cst_checker u_cst_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the counting semaphore table: directed create,
// wait, signal and free cases, then random call sequences on a small set of
// names, with random gaps on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned Q_DEPTH   = 8;
  localparam int unsigned WATCHDOG  = 20000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  cst_pkg::req_t  in_data;
  logic           out_valid;
  logic           out_stall;
  cst_pkg::rsp_t  out_data;

  counting_semaphore_table u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // shadow copy of the semaphore table
  logic              sh_used  [NUM_SLOTS];
  logic [9:0]        sh_owner [NUM_SLOTS];
  logic [63:0]       sh_name  [NUM_SLOTS];
  int                sh_count [NUM_SLOTS];
  logic [9:0]        sh_waiters [NUM_SLOTS][Q_DEPTH];
  int unsigned       sh_head  [NUM_SLOTS];
  int unsigned       sh_fill  [NUM_SLOTS];

  cst_pkg::rsp_t expected_rsp_q[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned transfers_in;
  int unsigned idle_cycles;
  int unsigned hold_cycles;   // > 0 forces a long receiver hold-off
  bit          timed_out;

  // small name pool so random calls hit existing semaphores
  logic [63:0] name_pool [8];
  logic [9:0]  owner_pool [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_sem(input logic [9:0] owner, input logic [63:0] name);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sh_used[i] && sh_owner[i] == owner && sh_name[i] == name) return i;
    end
    return -1;
  endfunction

  function automatic void clear_sem(input int i);
    sh_used[i]  = 1'b0;
    sh_owner[i] = '0;
    sh_name[i]  = '0;
    sh_count[i] = 0;
    sh_head[i]  = 0;
    sh_fill[i]  = 0;
  endfunction

  // apply one call to the shadow table and return the expected response
  function automatic cst_pkg::rsp_t apply_call(input cst_pkg::req_t rq);
    cst_pkg::rsp_t r;
    int   s;
    int   f;
    int unsigned pos;
    r = '0;
    r.status = cst_pkg::ST_OK;
    case (cst_pkg::op_e'(rq.op))
      cst_pkg::OP_CREATE: begin
        s = find_sem(rq.owner_id, rq.name_tag);
        if (s >= 0) begin
          r.status = cst_pkg::ST_EXISTS;
          r.sem_id = s[3:0];
        end else begin
          f = -1;
          for (int i = NUM_SLOTS - 1; i >= 0; i--) if (!sh_used[i]) f = i;
          if (f < 0) begin
            r.status = cst_pkg::ST_FULL;
          end else begin
            clear_sem(f);
            sh_used[f]  = 1'b1;
            sh_owner[f] = rq.owner_id;
            sh_name[f]  = rq.name_tag;
            sh_count[f] = int'(rq.initial_value);
            r.sem_id    = f[3:0];
          end
        end
      end
      cst_pkg::OP_WAIT, cst_pkg::OP_SIGNAL: begin
        s = find_sem(rq.owner_id, rq.name_tag);
        if (s < 0) begin
          r.status = cst_pkg::ST_NOTFOUND;
        end else begin
          r.sem_id = s[3:0];
          if (cst_pkg::op_e'(rq.op) == cst_pkg::OP_WAIT) begin
            if (sh_count[s] <= -32768) begin
              r.status = cst_pkg::ST_LIMIT;
            end else if (sh_count[s] - 1 < 0) begin
              if (sh_fill[s] >= Q_DEPTH) begin
                r.status = cst_pkg::ST_LIMIT;
              end else begin
                pos = (sh_head[s] + sh_fill[s]) % Q_DEPTH;
                sh_waiters[s][pos] = rq.env_id;
                sh_fill[s]++;
                sh_count[s]--;
                r.blocked = 1'b1;
              end
            end else begin
              sh_count[s]--;
            end
          end else begin
            if (sh_count[s] >= 32767) begin
              r.status = cst_pkg::ST_LIMIT;
            end else begin
              sh_count[s]++;
              // wake the oldest waiter while the count stays non-positive
              if (sh_count[s] <= 0 && sh_fill[s] > 0) begin
                r.wake_valid = 1'b1;
                r.woken_env  = sh_waiters[s][sh_head[s]];
                sh_head[s]   = (sh_head[s] + 1) % Q_DEPTH;
                sh_fill[s]--;
              end
            end
          end
        end
      end
      default: begin
        r.sem_id = rq.sem_index[3:0];
        if (rq.sem_index >= NUM_SLOTS) r.status = cst_pkg::ST_NOTFOUND;
        else clear_sem(int'(rq.sem_index));
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one transfer into the block; expectation is recorded at acceptance
  task automatic send_call(input cst_pkg::req_t rq, input bit gaps);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rsp_q.push_back(apply_call(rq));
    transfers_in++;
  endtask

  function automatic cst_pkg::req_t make_call(input cst_pkg::op_e op,
                                              input logic [9:0] owner,
                                              input logic [63:0] name,
                                              input logic [14:0] init,
                                              input logic [9:0] env,
                                              input logic [4:0] idx);
    cst_pkg::req_t rq;
    rq.op            = op;
    rq.owner_id      = owner;
    rq.name_tag      = name;
    rq.initial_value = init;
    rq.env_id        = env;
    rq.sem_index     = idx;
    return rq;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0 && !timed_out) @(posedge clk);
  endtask

  task automatic test_directed();
    // create at both ends of the initial value range and with full-width fields
    send_call(make_call(cst_pkg::OP_CREATE, 10'h3ff, '1, 15'h7fff, 10'h3ff, 5'h1f), 1'b0);
    send_call(make_call(cst_pkg::OP_CREATE, 10'h000, '0, 15'h0000, 10'h000, 5'h00), 1'b0);
    // duplicate pair reports the existing slot
    send_call(make_call(cst_pkg::OP_CREATE, 10'h3ff, '1, 15'h0001, 10'h001, 5'h00), 1'b0);
    // wait on a zero count blocks, then signal wakes it
    send_call(make_call(cst_pkg::OP_WAIT, 10'h000, '0, 15'h0, 10'h2aa, 5'h0), 1'b0);
    send_call(make_call(cst_pkg::OP_WAIT, 10'h000, '0, 15'h0, 10'h155, 5'h0), 1'b0);
    send_call(make_call(cst_pkg::OP_SIGNAL, 10'h000, '0, 15'h0, 10'h0, 5'h0), 1'b0);
    send_call(make_call(cst_pkg::OP_SIGNAL, 10'h000, '0, 15'h0, 10'h0, 5'h0), 1'b0);
    // signal with empty queue and non-positive count, then a missing name
    send_call(make_call(cst_pkg::OP_SIGNAL, 10'h000, '0, 15'h0, 10'h0, 5'h0), 1'b0);
    send_call(make_call(cst_pkg::OP_WAIT, 10'h123, 64'h5555_aaaa_5555_aaaa, 15'h0,
                        10'h0, 5'h0), 1'b0);
    send_call(make_call(cst_pkg::OP_SIGNAL, 10'h123, 64'h5555_aaaa_5555_aaaa, 15'h0,
                        10'h0, 5'h0), 1'b0);
    // signal at the highest count
    send_call(make_call(cst_pkg::OP_SIGNAL, 10'h3ff, '1, 15'h0, 10'h0, 5'h0), 1'b0);
    // free out of range, free unused, free used
    send_call(make_call(cst_pkg::OP_FREE, 10'h0, '0, 15'h0, 10'h0, 5'h1f), 1'b0);
    send_call(make_call(cst_pkg::OP_FREE, 10'h0, '0, 15'h0, 10'h0, 5'h05), 1'b0);
    send_call(make_call(cst_pkg::OP_FREE, 10'h0, '0, 15'h0, 10'h0, 5'h00), 1'b0);
    send_call(make_call(cst_pkg::OP_FREE, 10'h0, '0, 15'h0, 10'h0, 5'h01), 1'b0);
    wait_drained();
  endtask

  // queue overflow on one semaphore, then drain it with signals
  task automatic test_queue_full();
    send_call(make_call(cst_pkg::OP_CREATE, 10'h010, 64'h4d55_5445_5800_0000, 15'h0,
                        10'h0, 5'h0), 1'b1);
    for (int i = 0; i < Q_DEPTH + 2; i++) begin
      send_call(make_call(cst_pkg::OP_WAIT, 10'h010, 64'h4d55_5445_5800_0000, 15'h0,
                          10'(i * 97 + 3), 5'h0), 1'b1);
    end
    for (int i = 0; i < Q_DEPTH + 1; i++) begin
      send_call(make_call(cst_pkg::OP_SIGNAL, 10'h010, 64'h4d55_5445_5800_0000, 15'h0,
                          10'h0, 5'h0), 1'b1);
    end
    wait_drained();
  endtask

  // fill the table, overflow it, then clear every slot
  task automatic test_table_full();
    for (int i = 0; i < NUM_SLOTS + 2; i++) begin
      send_call(make_call(cst_pkg::OP_CREATE, 10'(i), {$urandom, $urandom}, 15'($urandom),
                          10'h0, 5'h0), 1'b1);
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_call(make_call(cst_pkg::OP_FREE, 10'h0, '0, 15'h0, 10'h0, 5'(i)), 1'b1);
    end
    wait_drained();
  endtask

  // long receiver hold-off while calls keep arriving back to back
  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 12; i++) begin
      send_call(make_call(cst_pkg::OP_CREATE, owner_pool[i % 4], name_pool[i % 8], 15'd2,
                          10'h0, 5'h0), 1'b0);
    end
    wait_drained();
  endtask

  task automatic test_random(input int unsigned n_calls);
    cst_pkg::req_t rq;
    int unsigned   p;
    for (int k = 0; k < n_calls; k++) begin
      rq.owner_id      = owner_pool[$urandom_range(0, 3)];
      rq.name_tag      = name_pool[$urandom_range(0, 7)];
      rq.initial_value = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3));
      rq.env_id        = 10'($urandom);
      rq.sem_index     = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 15));
      p = $urandom_range(0, 99);
      if (p < 15) rq.op = cst_pkg::OP_CREATE;
      else if (p < 55) rq.op = cst_pkg::OP_WAIT;
      else if (p < 93) rq.op = cst_pkg::OP_SIGNAL;
      else rq.op = cst_pkg::OP_FREE;
      // occasional noise: unknown names and owners
      if ($urandom_range(0, 19) == 0) begin
        rq.name_tag = {$urandom, $urandom};
        rq.owner_id = 10'($urandom);
      end
      send_call(rq, 1'b1);
    end
    wait_drained();
  endtask

  // result checker and receiver stall generator
  initial begin
    cst_pkg::rsp_t exp_rsp;
    int unsigned   gap;
    out_stall = 1'b1;
    gap = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (out_data !== exp_rsp) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected status %0d id %0d blk %0b wake %0b env %0d",
                       exp_rsp.status, exp_rsp.sem_id, exp_rsp.blocked,
                       exp_rsp.wake_valid, exp_rsp.woken_env);
              $display("          actual   status %0d id %0d blk %0b wake %0b env %0d",
                       out_data.status, out_data.sem_id, out_data.blocked,
                       out_data.wake_valid, out_data.woken_env);
            end
          end
        end
      end
      // one nonblocking update of out_stall per edge
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_stall <= 1'b1;
      end else begin
        gap = gap_len();
        out_stall <= (gap != 0);
        if (gap != 0) gap--;
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        timed_out = 1'b1;
        $display("[counting_semaphore_table] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    mismatches   = 0;
    results_seen = 0;
    transfers_in = 0;
    idle_cycles  = 0;
    hold_cycles  = 0;
    timed_out    = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) clear_sem(i);
    for (int i = 0; i < 8; i++) name_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < 4; i++) owner_pool[i] = 10'($urandom);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_queue_full();
    test_table_full();
    test_backpressure();
    test_random(330);

    repeat (20) @(posedge clk);
    $display("covered %0d calls and %0d results: create, wait, signal, free,",
             transfers_in, results_seen);
    $display("queue and table overflow, count limit and a long output hold-off");
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("[counting_semaphore_table] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_rsp_q.size());
      $display("[counting_semaphore_table] ERROR");
    end
    $finish;
  end

endmodule
